// ===== rtl/fdss_pkg.sv =====
// Package for the four-digit seven-segment scanner: command codes, the
// constant reciprocals used for the decimal split, and the glyph and anode
// decoders. No dependencies.
package fdss_pkg;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_SCAN = 1'b1
    } t_cmd;

    typedef logic [3:0]  t_digit;
    typedef logic [1:0]  t_pos;
    typedef logic [13:0] t_value;

    localparam t_value DISPLAY_MAX = 14'd9999;

    // floor(v * K >> S) equals floor(v / D) for every v up to 9999
    localparam int PROD_W    = 28;
    localparam int RECIP_1000 = 8389;
    localparam int SHIFT_1000 = 23;
    localparam int RECIP_100  = 5243;
    localparam int SHIFT_100  = 19;
    localparam int RECIP_10   = 6554;
    localparam int SHIFT_10   = 16;

    localparam logic [7:0] SEG_DARK = 8'hFF;

    // Active-high segment pattern of a decimal digit; codes above 9 stay dark.
    function automatic logic [7:0] digit_glyph(input t_digit d);
        logic [7:0] g;
        unique case (d)
            4'd0:    g = 8'h3f;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5b;
            4'd3:    g = 8'h4f;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6d;
            4'd6:    g = 8'h7d;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7f;
            4'd9:    g = 8'h6f;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    // Letters of STOP, position 3 is the leftmost.
    function automatic logic [7:0] stop_glyph(input t_pos p);
        logic [7:0] g;
        unique case (p)
            2'd0: g = 8'h73;
            2'd1: g = 8'h5c;
            2'd2: g = 8'h78;
            2'd3: g = 8'h6d;
        endcase
        return g;
    endfunction

    function automatic logic [3:0] anode_code(input t_pos p);
        logic [3:0] a;
        unique case (p)
            2'd0: a = 4'hE;
            2'd1: a = 4'hD;
            2'd2: a = 4'hB;
            2'd3: a = 4'h7;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/four_digit_seven_segment_scanner_top.sv =====
// Four-digit seven-segment scanner: input register, decimal split or glyph
// lookup, result register. Depends on fdss_pkg.
// A scan item passes the input register, then the result register.
// Throughput: one item per cycle without output stalls; those two are the
// only stages. Loads give no result and never wait on the output side.
// Reset (synchronous, active low): digits zero, position zero, stop mode off.
module four_digit_seven_segment_scanner_top
    import fdss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [13:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_anode,
    output logic [7:0]  o_segments
);

    logic        r_stop_mode;
    logic        r_in_vld;
    t_cmd        r_in_cmd;
    t_value      r_in_val;
    t_digit      r_digits [4];
    t_pos        r_pos;
    logic        r_out_vld;
    logic [3:0]  r_anode;
    logic [7:0]  r_seg;

    logic        s_out_free;
    logic        s_move;
    logic        s_take;
    t_value      n_in_val;

    logic [PROD_W-1:0] s_p1000, s_p100, s_p10;
    logic [3:0]  s_q1000;
    logic [6:0]  s_q100;
    logic [9:0]  s_q10;
    t_digit      s_d3, s_d2, s_d1, s_d0;
    logic [6:0]  s_t2;
    logic [9:0]  s_t1;
    t_value      s_t0;
    logic [7:0]  s_lit;

    // Output register frees up when empty or being drained this cycle.
    assign s_out_free = !r_out_vld || !i_out_stall;
    assign s_move     = r_in_vld && (r_in_cmd == CMD_LOAD || s_out_free);
    assign o_in_stall = r_in_vld && !s_move;
    assign s_take     = i_in_valid && !o_in_stall;

    assign n_in_val = (i_value > DISPLAY_MAX) ? DISPLAY_MAX : i_value;

    // Decimal split by constant reciprocals, all from the saturated value.
    assign s_p1000 = PROD_W'(r_in_val) * PROD_W'(RECIP_1000);
    assign s_p100  = PROD_W'(r_in_val) * PROD_W'(RECIP_100);
    assign s_p10   = PROD_W'(r_in_val) * PROD_W'(RECIP_10);
    assign s_q1000 = s_p1000[SHIFT_1000 +: 4];
    assign s_q100  = s_p100[SHIFT_100 +: 7];
    assign s_q10   = s_p10[SHIFT_10 +: 10];

    assign s_t2 = 7'(s_q100) - ((7'(s_q1000) << 3) + (7'(s_q1000) << 1));
    assign s_t1 = s_q10 - ((10'(s_q100) << 3) + (10'(s_q100) << 1));
    assign s_t0 = r_in_val - ((14'(s_q10) << 3) + (14'(s_q10) << 1));
    assign s_d3 = s_q1000;
    assign s_d2 = s_t2[3:0];
    assign s_d1 = s_t1[3:0];
    assign s_d0 = s_t0[3:0];

    assign s_lit = r_stop_mode ? stop_glyph(r_pos) : digit_glyph(r_digits[r_pos]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_stop_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_take) begin
            r_in_vld <= 1'b1;
        end else if (s_move) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_cmd <= t_cmd'(i_cmd);
            r_in_val <= n_in_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_digits[i] <= '0;
            r_pos <= '0;
        end else if (s_move) begin
            if (r_in_cmd == CMD_LOAD) begin
                r_digits[0] <= s_d0;
                r_digits[1] <= s_d1;
                r_digits[2] <= s_d2;
                r_digits[3] <= s_d3;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_out_free) begin
            r_out_vld <= s_move && r_in_cmd == CMD_SCAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_move && r_in_cmd == CMD_SCAN) begin
            r_anode <= anode_code(r_pos);
            r_seg   <= ~s_lit;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_anode     = r_anode;
    assign o_segments  = r_seg;

    a_anode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $onehot(~r_anode))
        else $error("anode pattern lights other than one position");

    a_dp_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_seg[7])
        else $error("decimal point lit");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digits[0] <= 4'd9 && r_digits[1] <= 4'd9 &&
        r_digits[2] <= 4'd9 && r_digits[3] <= 4'd9)
        else $error("stored digit above nine");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_move && r_in_cmd == CMD_SCAN) |=> r_pos == $past(r_pos) + 2'd1)
        else $error("scan position did not advance");

    a_rose_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(s_move && r_in_cmd == CMD_SCAN))
        else $error("result appeared without a scan item");

endmodule
